[hw/rtl/wvm_pkg.sv]
// shared types, constants and the radix-256 fold step for the wide modulo block
// no dependencies
`timescale 1ns / 1ps

package wvm_pkg;

    localparam int WordW      = 32;
    localparam int WordCount  = 8;
    localparam int ValueW     = WordW * WordCount;
    localparam int RemW       = 16;
    localparam int DivW       = RemW + 1;
    localparam int DigitW     = 8;
    localparam int StageCount = ValueW / DigitW;
    localparam logic [RemW-1:0] ResetDivisor = RemW'(210);

    typedef struct packed {
        logic              valid;
        logic [RemW-1:0]   rem;
        logic [ValueW-1:0] value;
    } t_stage_word;

    // zero in the register means 2^16
    function automatic logic [DivW-1:0] f_eff_div(input logic [RemW-1:0] div);
        logic [DivW-1:0] d;
        d = (div == '0) ? {1'b1, {RemW{1'b0}}} : {1'b0, div};
        return d;
    endfunction

    // one restoring step per bit, msb first
    function automatic logic [RemW-1:0] f_fold(input logic [RemW-1:0] rem,
                                               input logic [DigitW-1:0] digit,
                                               input logic [DivW-1:0] div);
        logic [DivW-1:0] acc;
        acc = {1'b0, rem};
        for (int i = DigitW - 1; i >= 0; i--) begin
            acc = {acc[RemW-1:0], digit[i]};
            if (acc >= div) begin
                acc = acc - div;
            end
        end
        return acc[RemW-1:0];
    endfunction

endpackage

[hw/rtl/wide_value_mod_small_divisor.sv]
// top level: 256-bit value modulo a configured 16-bit divisor
// depends on wvm_pkg and wvm_digit_stage
`timescale 1ns / 1ps

// Reduces a 256-bit unsigned value, given as eight 32-bit words, modulo the
// divisor register (reset 210, zero reads as 65536) and returns the remainder
// and a flag for a zero remainder. The value runs through a chain of 32
// stages, each folding one byte into the running remainder with eight
// compare-subtract steps; a new word is taken every cycle unless
// back-pressure reaches the input. Every stage has its own valid bit and a
// stalled output backs up only as far as bubbles allow. A divisor write is
// held off (o_cfg_ready low) until the pipeline is empty and no word is
// offered at the input.
module wide_value_mod_small_divisor
    import wvm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [RemW-1:0]  i_divisor,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WordW-1:0] i_word_0,
    input  logic [WordW-1:0] i_word_1,
    input  logic [WordW-1:0] i_word_2,
    input  logic [WordW-1:0] i_word_3,
    input  logic [WordW-1:0] i_word_4,
    input  logic [WordW-1:0] i_word_5,
    input  logic [WordW-1:0] i_word_6,
    input  logic [WordW-1:0] i_word_7,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RemW-1:0]  o_remainder,
    output logic             o_is_multiple
);

    logic [RemW-1:0] r_divisor;
    logic [DivW-1:0] w_div;
    logic            w_busy;
    t_stage_word     w_word  [StageCount+1];
    logic            w_ready [StageCount+1];

    // any word still in flight
    always_comb begin
        w_busy = 1'b0;
        for (int k = 1; k <= StageCount; k++) begin
            w_busy = w_busy || w_word[k].valid;
        end
    end

    assign o_cfg_ready = !w_busy && !i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= ResetDivisor;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_divisor <= i_divisor;
        end
    end

    assign w_div = f_eff_div(r_divisor);

    assign w_word[0].valid = i_valid;
    assign w_word[0].rem   = '0;
    assign w_word[0].value = {i_word_7, i_word_6, i_word_5, i_word_4,
                              i_word_3, i_word_2, i_word_1, i_word_0};
    assign o_ready = w_ready[0];

    for (genvar g = 0; g < StageCount; g++) begin : g_stage
        wvm_digit_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (w_div),
            .i_word  (w_word[g]),
            .o_ready (w_ready[g]),
            .o_word  (w_word[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    assign w_ready[StageCount] = i_ready;
    assign o_valid       = w_word[StageCount].valid;
    assign o_remainder   = w_word[StageCount].rem;
    assign o_is_multiple = (w_word[StageCount].rem == '0);

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_remainder} < w_div))
        else $error("remainder not below divisor");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_remainder)))
        else $error("stalled result changed");
`endif

endmodule

[hw/rtl/wvm_digit_stage.sv]
// one pipeline stage: folds the top byte of the remaining value into the remainder
// depends on wvm_pkg
`timescale 1ns / 1ps

module wvm_digit_stage
    import wvm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [DivW-1:0] i_div,
    input  t_stage_word     i_word,
    output logic            o_ready,
    output t_stage_word     o_word,
    input  logic            i_ready
);

    logic              r_valid;
    logic [RemW-1:0]   r_rem;
    logic [ValueW-1:0] r_value;
    logic              n_valid;
    logic [RemW-1:0]   n_rem;
    logic [ValueW-1:0] n_value;
    logic              w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_word.valid && o_ready;
    assign n_valid = w_take ? 1'b1 : (r_valid && !i_ready);
    assign n_rem   = f_fold(i_word.rem, i_word.value[ValueW-1 -: DigitW], i_div);
    assign n_value = {i_word.value[ValueW-DigitW-1:0], {DigitW{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rem   <= n_rem;
            r_value <= n_value;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.rem   = r_rem;
    assign o_word.value = r_value;

endmodule

[tb/wide_value_mod_small_divisor_tb.sv]
// testbench for wide_value_mod_small_divisor: 256-bit value modulo a 16-bit divisor
// depends on wvm_pkg and the block's rtl; predicts each remainder with a bit-serial fold
`timescale 1ns / 1ps

module wide_value_mod_small_divisor_tb;
    import wvm_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [RemW-1:0]  i_divisor;
    logic             i_valid;
    logic             o_ready;
    logic [WordW-1:0] i_word_0, i_word_1, i_word_2, i_word_3;
    logic [WordW-1:0] i_word_4, i_word_5, i_word_6, i_word_7;
    logic             o_valid;
    logic             i_ready;
    logic [RemW-1:0]  o_remainder;
    logic             o_is_multiple;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic            mult;
    } t_mod_result;

    t_mod_result     pending_rems[$];
    logic [RemW-1:0] divisor_reg;
    int              fail_count;
    int              cycle_count;
    bit              sink_stall_on;

    localparam int CycleLimit = 2000000;

    wide_value_mod_small_divisor u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_divisor(i_divisor),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_word_0(i_word_0), .i_word_1(i_word_1), .i_word_2(i_word_2),
        .i_word_3(i_word_3), .i_word_4(i_word_4), .i_word_5(i_word_5),
        .i_word_6(i_word_6), .i_word_7(i_word_7),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_remainder(o_remainder), .o_is_multiple(o_is_multiple)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // exact remainder, one value bit at a time, msb first
    function automatic t_mod_result f_value_mod(input logic [ValueW-1:0] value,
                                                input logic [RemW-1:0] div);
        logic [RemW+1:0] acc;
        logic [RemW+1:0] d;
        t_mod_result     res;
        d = (div == '0) ? (18'd1 << RemW) : {2'b00, div};
        acc = '0;
        for (int i = ValueW - 1; i >= 0; i--) begin
            acc = {acc[RemW:0], value[i]};
            if (acc >= d) acc = acc - d;
        end
        res.rem = acc[RemW-1:0];
        res.mult = (acc == '0);
        return res;
    endfunction

    function automatic logic [WordW-1:0] f_rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // drops valid only when a real gap follows
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_value(input logic [ValueW-1:0] value, input bit gaps);
        if (gaps && $urandom_range(0, 2) == 0) idle_gap();
        i_valid  <= 1'b1;
        i_word_0 <= value[31:0];    i_word_1 <= value[63:32];
        i_word_2 <= value[95:64];   i_word_3 <= value[127:96];
        i_word_4 <= value[159:128]; i_word_5 <= value[191:160];
        i_word_6 <= value[223:192]; i_word_7 <= value[255:224];
        do @(posedge i_clk); while (!o_ready);
        pending_rems.push_back(f_value_mod(value, divisor_reg));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_rems.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_divisor(input logic [RemW-1:0] div);
        drain();
        i_cfg_valid <= 1'b1;
        i_divisor   <= div;
        do @(posedge i_clk); while (!o_cfg_ready);
        divisor_reg = div;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [ValueW-1:0] f_rand_value();
        logic [ValueW-1:0] v;
        for (int k = 0; k < WordCount; k++) v[k*WordW +: WordW] = f_rand_word();
        return v;
    endfunction

    // checker: compares each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rems.size() == 0) begin
                $display("%0t: unexpected result rem=%0d mult=%0b",
                         $realtime, o_remainder, o_is_multiple);
                fail_count++;
            end else begin
                t_mod_result exp_res;
                exp_res = pending_rems.pop_front();
                if (o_remainder !== exp_res.rem) begin
                    $display("%0t: remainder expected %0d actual %0d",
                             $realtime, exp_res.rem, o_remainder);
                    fail_count++;
                end
                if (o_is_multiple !== exp_res.mult) begin
                    $display("%0t: is_multiple expected %0b actual %0b",
                             $realtime, exp_res.mult, o_is_multiple);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure, off during some stretches
    always @(posedge i_clk) begin
        if (!sink_stall_on) i_ready <= 1'b1;
        else if ($urandom_range(0, 15) == 0) i_ready <= 1'b0;
        else if (!i_ready && $urandom_range(0, 3) != 0) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic test_reset_divisor();
        logic [ValueW-1:0] v;
        send_value('0, 0);
        send_value('1, 0);
        v = '0; v[7:0] = 8'd210; send_value(v, 0);
        v = '0; v[7:0] = 8'd209; send_value(v, 0);
        v = '0; v[255] = 1'b1; send_value(v, 0);
    endtask

    task automatic test_divisor_extremes();
        logic [ValueW-1:0] v;
        write_divisor(16'd1);
        send_value('1, 0);
        send_value(f_rand_value(), 0);
        write_divisor(16'hFFFF);
        send_value('1, 0);
        v = '0; v[15:0] = 16'hFFFF; send_value(v, 0);
        v = '0; v[15:0] = 16'hFFFE; send_value(v, 0);
        // zero register acts as 65536, remainder is the low half-word
        write_divisor(16'd0);
        send_value('1, 0);
        v = '1; v[15:0] = '0; send_value(v, 0);
        send_value({8{32'h8000_0000}}, 0);
        write_divisor(16'h8000);
        send_value('1, 0);
        send_value({8{32'h5555_5555}}, 0);
        write_divisor(16'd2);
        send_value({8{32'hAAAA_AAAA}}, 0);
        send_value('1, 0);
    endtask

    task automatic test_random_values();
        logic [RemW-1:0] div;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: div = 16'($urandom_range(1, 255));
                1: div = 16'($urandom);
                2: div = 16'(1) << $urandom_range(0, 15);
                default: div = 16'($urandom_range(65000, 65535));
            endcase
            if (phase == 7) div = '0;
            write_divisor(div);
            sink_stall_on = (phase % 3 != 2);
            for (int n = 0; n < 100; n++) send_value(f_rand_value(), phase % 3 != 1);
        end
    endtask

    initial begin
        cycle_count   = 0;
        fail_count    = 0;
        divisor_reg   = ResetDivisor;
        sink_stall_on = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_divisor   = '0;
        i_valid     = 1'b0;
        i_ready     = 1'b1;
        {i_word_0, i_word_1, i_word_2, i_word_3} = '0;
        {i_word_4, i_word_5, i_word_6, i_word_7} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_divisor();
        test_divisor_extremes();
        test_random_values();
        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/wvm_pkg.sv
hw/rtl/wvm_digit_stage.sv
hw/rtl/wide_value_mod_small_divisor.sv
tb/wide_value_mod_small_divisor_tb.sv
